// ===== src/ppsc_pkg.sv =====
package ppsc_pkg;

    localparam int BYTE_W                = 8;
    localparam int LEN_W                 = 16;
    localparam int VERDICT_W             = 3;
    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int S_TDATA_W             = 24;
    localparam int M_TDATA_W             = 8;

    localparam logic [BYTE_W-1:0] FIRST_BYTE_HOLD = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE       = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_EIGHT      = 8'h38;

    localparam logic [LEN_W-1:0] LEN_ONE      = 16'd1;
    localparam logic [LEN_W-1:0] LEN_GET      = 16'd3;
    localparam logic [LEN_W-1:0] LEN_SEND     = 16'd4;
    localparam logic [LEN_W-1:0] LEN_PATTERN  = 16'd149;
    localparam logic [LEN_W-1:0] LEN_TAIL_MIN = 16'd10;
    localparam logic [LEN_W-1:0] LEN_TAIL_MAX = 16'd1000;

    typedef enum logic [1:0] {
        DEC_SEARCHING = 2'd0,
        DEC_FOUND     = 2'd1,
        DEC_EXCLUDED  = 2'd2
    } decision_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_UNDECIDED   = 3'd0,
        VERDICT_STAGE_ONE   = 3'd1,
        VERDICT_FOUND       = 3'd2,
        VERDICT_EXCLUDED    = 3'd3,
        VERDICT_NOT_CHECKED = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic              send_ok;
        logic              get_ok;
        logic              pattern_ok;
        logic              tail_digits;
    } pkt_state_t;

    typedef struct packed {
        logic      stage;
        decision_t decision;
    } flow_state_t;

    localparam pkt_state_t PKT_STATE_RESET = '{
        first_byte:  '0,
        send_ok:     1'b1,
        get_ok:      1'b1,
        pattern_ok:  1'b1,
        tail_digits: 1'b0
    };

    localparam flow_state_t FLOW_STATE_RESET = '{stage: 1'b0, decision: DEC_SEARCHING};

    function automatic logic [BYTE_W-1:0] send_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = 8'h53;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h4E;
            default: c = 8'h44;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] get_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    // offset below 149 assumed
    function automatic logic pattern_byte_ok(input logic [7:0] pos, input logic [BYTE_W-1:0] b);
        logic ok;
        if (pos == 8'd0)
            ok = (b == CHAR_EIGHT);
        else if (pos inside {[8'd17:8'd28], 8'd39, 8'd40})
            ok = (b == 8'h00);
        else if (pos == 8'd135)
            ok = (b == 8'h7E);
        else if (pos == 8'd136)
            ok = (b == 8'hDF);
        else if (pos == 8'd147)
            ok = (b == 8'hF7);
        else if (pos == 8'd148)
            ok = (b == 8'h92);
        else
            ok = 1'b1;
        return ok;
    endfunction

endpackage

// ===== src/ppsc_byte_check.sv =====
module ppsc_byte_check #(
    parameter int POSITION_BITS = ppsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [ppsc_pkg::BYTE_W-1:0] data_byte,
    input  ppsc_pkg::pkt_state_t     cur,
    output ppsc_pkg::pkt_state_t     upd
);
    import ppsc_pkg::*;

    logic pos_zero;
    logic pos_lt3;
    logic pos_lt4;
    logic pos_lt149;
    logic is_digit;

    assign pos_zero  = (pos == '0);
    assign pos_lt3   = (pos < POSITION_BITS'(3));
    assign pos_lt4   = (pos < POSITION_BITS'(4));
    assign pos_lt149 = (pos < POSITION_BITS'(149));
    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

    always_comb
    begin
        upd = cur;
        if (pos_zero)
            upd.first_byte = data_byte;
        if (!pos_lt4 || data_byte != send_char(pos[1:0]))
            upd.send_ok = 1'b0;
        if (!pos_lt3 || data_byte != get_char(pos[1:0]))
            upd.get_ok = 1'b0;
        if (!pos_lt149 || !pattern_byte_ok(pos[7:0], data_byte))
            upd.pattern_ok = 1'b0;
        if (pos_zero)
            upd.tail_digits = 1'b0;
        else if (data_byte == CHAR_SPACE)
            upd.tail_digits = 1'b1;
        else if (!is_digit)
            upd.tail_digits = 1'b0;
    end

endmodule

// ===== src/ppsc_verdict.sv =====
module ppsc_verdict #(
    parameter int POSITION_BITS = ppsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic [POSITION_BITS-1:0]   pos,
    input  logic [ppsc_pkg::LEN_W-1:0] len,
    input  ppsc_pkg::pkt_state_t       pkt,
    input  ppsc_pkg::flow_state_t      flow_cur,
    output ppsc_pkg::flow_state_t      flow_upd,
    output ppsc_pkg::verdict_t         verdict
);
    import ppsc_pkg::*;

    logic [LEN_W:0] pos_count;
    logic           count_ok;

    assign pos_count = (LEN_W + 1)'(pos) + 1'b1;
    assign count_ok  = (pos_count == {1'b0, len});

    always_comb
    begin
        flow_upd = flow_cur;
        verdict  = VERDICT_EXCLUDED;
        if (flow_cur.decision != DEC_SEARCHING)
        begin
            verdict = VERDICT_NOT_CHECKED;
        end
        else if (!flow_cur.stage)
        begin
            if (len == LEN_ONE || (len > LEN_ONE && pkt.first_byte == FIRST_BYTE_HOLD))
                verdict = VERDICT_UNDECIDED;
            else if (count_ok && len == LEN_SEND && pkt.send_ok)
            begin
                verdict        = VERDICT_STAGE_ONE;
                flow_upd.stage = 1'b1;
            end
            else if ((count_ok && len == LEN_GET && pkt.get_ok) ||
                     (count_ok && len == LEN_PATTERN && pkt.pattern_ok))
            begin
                verdict           = VERDICT_FOUND;
                flow_upd.decision = DEC_FOUND;
            end
            else
                flow_upd.decision = DEC_EXCLUDED;
        end
        else
        begin
            if (count_ok && len > LEN_TAIL_MIN && len < LEN_TAIL_MAX && pkt.tail_digits)
            begin
                verdict           = VERDICT_FOUND;
                flow_upd.decision = DEC_FOUND;
            end
            else
                flow_upd.decision = DEC_EXCLUDED;
        end
    end

endmodule

// ===== src/p2p_payload_signature_classifier.sv =====
// Classifies one TCP flow from its payload, one byte per word, and gives one verdict word
// on every word marked last. A word is taken while tready is high; it is held in an input
// register, then combinational compare logic updates the flow state and loads the
// verdict into the output register, so the block sustains one word per cycle while the
// input is not stalled. A waiting verdict stalls the input only when the next word is also a
// last word. Raise tuser on the first word of a flow to clear its state.
module p2p_payload_signature_classifier #(
    parameter int POSITION_BITS = ppsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ppsc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // payload_byte, payload_length
    input  logic                           s_axis_tlast,  // last_byte
    input  logic                           s_axis_tuser,  // new_flow
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ppsc_pkg::M_TDATA_W-1:0] m_axis_tdata   // verdict, zero fill
);
    import ppsc_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                     in_valid_reg;
    logic [BYTE_W-1:0]        in_byte_reg;
    logic [LEN_W-1:0]         in_len_reg;
    logic                     in_last_reg;
    logic                     in_fresh_reg;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    pkt_state_t               pkt_reg, pkt_next;
    flow_state_t              flow_reg, flow_next;

    logic                     out_valid_reg, out_valid_next;
    verdict_t                 out_verdict_reg;

    logic [POSITION_BITS-1:0] pos_cur;
    pkt_state_t               pkt_cur, pkt_upd;
    flow_state_t              flow_cur, flow_upd;
    verdict_t                 verdict;
    logic                     out_free;
    logic                     advance;
    logic                     accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_cur  = in_fresh_reg ? '0 : pos_reg;
    assign pkt_cur  = in_fresh_reg ? PKT_STATE_RESET : pkt_reg;
    assign flow_cur = in_fresh_reg ? FLOW_STATE_RESET : flow_reg;

    ppsc_byte_check #(
        .POSITION_BITS (POSITION_BITS)
    ) u_byte_check (
        .pos       (pos_cur),
        .data_byte (in_byte_reg),
        .cur       (pkt_cur),
        .upd       (pkt_upd)
    );

    ppsc_verdict #(
        .POSITION_BITS (POSITION_BITS)
    ) u_verdict (
        .pos      (pos_cur),
        .len      (in_len_reg),
        .pkt      (pkt_upd),
        .flow_cur (flow_cur),
        .flow_upd (flow_upd),
        .verdict  (verdict)
    );

    always_comb
    begin
        pos_next       = pos_reg;
        pkt_next       = pkt_reg;
        flow_next      = flow_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance)
        begin
            if (in_last_reg)
            begin
                // restart framing but keep the first byte seen
                pos_next            = '0;
                pkt_next            = PKT_STATE_RESET;
                pkt_next.first_byte = pkt_upd.first_byte;
                flow_next           = flow_upd;
                out_valid_next      = 1'b1;
            end
            else
            begin
                pos_next = (pos_cur != POS_MAX) ? pos_cur + 1'b1 : pos_cur;
                pkt_next = pkt_upd;
                flow_next = flow_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            pkt_reg       <= PKT_STATE_RESET;
            flow_reg      <= FLOW_STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= accept || (in_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            pkt_reg       <= pkt_next;
            flow_reg      <= flow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_len_reg   <= s_axis_tdata[BYTE_W +: LEN_W];
            in_last_reg  <= s_axis_tlast;
            in_fresh_reg <= s_axis_tuser;
        end
        if (advance && in_last_reg)
            out_verdict_reg <= verdict;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_verdict_reg);

endmodule

// ===== src/ppsc_checker.sv =====
module ppsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ppsc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tlast,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ppsc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ppsc_pkg::*;

    // hold an offered input word until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
        s_axis_tvalid && $stable({s_axis_tdata, s_axis_tlast, s_axis_tuser}))
        else $error("input word changed while stalled");

    // hold a stalled verdict word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict word changed while stalled");

    // show no verdict word after a reset cycle
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("verdict word shown during reset");

    // a second pending last word must stall the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready &&
        $past(s_axis_tvalid && s_axis_tready && s_axis_tlast) &&
        $past(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted with both stages full");

endmodule

bind p2p_payload_signature_classifier ppsc_checker u_ppsc_checker (.*);
